// ===== hw/rtl/tcw_pkg.sv =====
// Shared widths, value types and limits for the triangle cotangent weights block.
// Used by tcw_div and triangle_cotangent_weights_core; depends on nothing.
package tcw_pkg;

  localparam int COORD_W = 24;   // stored coordinate, Q12.12
  localparam int SLOT_W  = 12;   // slot and corner fields
  localparam int EDGE_W  = 25;   // difference of two coordinates
  localparam int OPND_W  = 26;   // multiplier operand
  localparam int PROD_W  = 52;   // multiplier product
  localparam int CROSS_W = 50;   // one cross product component
  localparam int MAG_W   = 49;   // magnitude of a cross component
  localparam int SUM_W   = 100;  // sum of squared cross components
  localparam int ROOT_W  = 50;   // integer square root of that sum
  localparam int DOT_W   = 51;   // edge dot product
  localparam int QUO_W   = 31;   // unsigned Q15.16 quotient
  localparam int COT_W   = 32;
  localparam int AREA_W  = 48;
  localparam int FRAC_W  = 16;   // fraction bits of a cotangent
  localparam int AREA_SH = 13;   // area = root / 2^13

  typedef logic signed [DOT_W-1:0] dot_t;
  typedef logic [ROOT_W-1:0]       root_t;
  typedef logic signed [COT_W-1:0] cot_t;

  localparam cot_t COT_MAX = 32'sh7FFF_FFFF;
  localparam cot_t COT_MIN = 32'sh8000_0000;

endpackage

// ===== hw/rtl/tcw_div.sv =====
// Iterative restoring divider: signed dot product over the root magnitude, Q16.16, saturated.
// Depends on tcw_pkg.
module tcw_div
  import tcw_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  dot_t  dot,
  input  root_t m,
  output logic  done,
  output cot_t  cot
);

  logic              busy;
  logic [4:0]        cnt;
  logic              neg;
  logic [ROOT_W-1:0] rem;
  logic [QUO_W-1:0]  low;
  logic [QUO_W-1:0]  q;

  logic [DOT_W-1:0]    mag;
  logic [ROOT_W+15:0]  lim;
  logic                sat;
  logic [ROOT_W:0]     trial;
  logic [ROOT_W:0]     diff;
  logic                ge;
  logic [QUO_W-1:0]    qf;

  always_comb begin
    mag   = dot[DOT_W-1] ? DOT_W'(-dot) : DOT_W'(dot);
    lim   = {1'b0, m, 15'b0};
    sat   = (ROOT_W+16)'(mag) >= lim;
    trial = {rem, low[QUO_W-1]};
    ge    = trial >= {1'b0, m};
    diff  = trial - {1'b0, m};
    qf    = {q[QUO_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        neg <= dot[DOT_W-1];
        if (sat) begin
          cot  <= dot[DOT_W-1] ? COT_MIN : COT_MAX;
          done <= 1'b1;
        end else begin
          busy <= 1'b1;
          cnt  <= 5'(QUO_W - 1);
          rem  <= ROOT_W'(mag >> 15);
          low  <= {mag[14:0], {FRAC_W{1'b0}}};
        end
      end else if (busy) begin
        rem <= ge ? diff[ROOT_W-1:0] : trial[ROOT_W-1:0];
        q   <= qf;
        low <= low << 1;
        cnt <= cnt - 5'd1;
        if (cnt == 5'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
          cot  <= neg ? -cot_t'({1'b0, qf}) : cot_t'({1'b0, qf});
        end
      end
    end
  end

endmodule

// ===== hw/rtl/triangle_cotangent_weights_core.sv =====
// Triangle cotangent weights core: vertex store, shared multiplier sequencer, square root.
// Depends on tcw_pkg and instantiates tcw_div.
//
// A write request (command 0) stores one vertex at vertex_slot; a query request (command 1)
// reads the three corner vertices and returns the corner cotangents in Q16.16 and the
// triangle area in Q36.12. A query makes three reads through the single read port of the
// vertex store, 24 products on one shared 26x26 multiplier, each registered and then
// accumulated (six for the cross product, nine for its squared length in partial products,
// nine for the three dot products), 50 steps of a bit-serial square root, and three passes
// of a divider that yields one quotient bit a cycle. The core stalls requests while a query
// is in progress, but a finished result sits in its own output register, so the next
// request is taken while that result waits. Slots at or beyond VERTEX_COUNT are ignored on
// write and read as the origin. A triangle whose cross product is zero reports degenerate
// with zero cotangents and zero area.
module triangle_cotangent_weights_core
  import tcw_pkg::*;
#(
  parameter int VERTEX_COUNT = 4096,
  parameter int COORD_BITS   = 24
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      req_valid,
  output logic                      req_stall,
  input  logic                      command,
  input  logic [SLOT_W-1:0]         vertex_slot,
  input  logic signed [COORD_W-1:0] coord_x,
  input  logic signed [COORD_W-1:0] coord_y,
  input  logic signed [COORD_W-1:0] coord_z,
  input  logic [SLOT_W-1:0]         corner_a,
  input  logic [SLOT_W-1:0]         corner_b,
  input  logic [SLOT_W-1:0]         corner_c,
  output logic                      res_valid,
  input  logic                      res_stall,
  output logic signed [COT_W-1:0]   cot_at_a,
  output logic signed [COT_W-1:0]   cot_at_b,
  output logic signed [COT_W-1:0]   cot_at_c,
  output logic [AREA_W-1:0]         tri_area,
  output logic                      degenerate
);

  localparam int ADDR_W = (VERTEX_COUNT > 1) ? $clog2(VERTEX_COUNT) : 1;
  localparam int CMP_W  = ((ADDR_W > SLOT_W) ? ADDR_W : SLOT_W) + 1;
  localparam int KEEP   = (COORD_BITS < COORD_W) ? COORD_BITS : COORD_W;
  localparam int SH     = COORD_W - KEEP;

  // Sequencer states.
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RA   = 4'd1;
  localparam logic [3:0] S_RB   = 4'd2;
  localparam logic [3:0] S_RC   = 4'd3;
  localparam logic [3:0] S_CAP  = 4'd4;
  localparam logic [3:0] S_EDGE = 4'd5;
  localparam logic [3:0] S_MUL  = 4'd6;
  localparam logic [3:0] S_SQI  = 4'd7;
  localparam logic [3:0] S_SQRT = 4'd8;
  localparam logic [3:0] S_DGO  = 4'd9;
  localparam logic [3:0] S_DWT  = 4'd10;
  localparam logic [3:0] S_DONE = 4'd11;

  // Multiplier step numbers: cross terms, then squared lengths, then dot products.
  localparam logic [4:0] OP_SQ   = 5'd6;
  localparam logic [4:0] OP_DA   = 5'd15;
  localparam logic [4:0] OP_DB   = 5'd18;
  localparam logic [4:0] OP_DC   = 5'd21;
  localparam logic [4:0] OP_LAST = 5'd23;

  function automatic logic slot_ok(input logic [SLOT_W-1:0] s);
    return CMP_W'(s) < CMP_W'(VERTEX_COUNT);
  endfunction

  function automatic logic [ADDR_W-1:0] slot_addr(input logic [SLOT_W-1:0] s);
    logic [CMP_W-1:0] e;
    e = CMP_W'(s);
    return e[ADDR_W-1:0];
  endfunction

  function automatic logic [COORD_W-1:0] fit(input logic [COORD_W-1:0] raw);
    logic signed [COORD_W-1:0] t;
    t = raw << SH;
    return t >>> SH;
  endfunction

  function automatic logic signed [OPND_W-1:0] sx(input logic signed [EDGE_W-1:0] e);
    return OPND_W'(e);
  endfunction

  logic [3:0] state;

  // Vertex store and its registered read port.
  logic [3*COORD_W-1:0] mem [VERTEX_COUNT];
  logic [ADDR_W-1:0]    rd_addr;
  logic [3*COORD_W-1:0] rd_data;
  logic                 rd_ok;
  logic                 rd_ok_next;

  logic [SLOT_W-1:0] ca, cb, cc;
  logic signed [COORD_W-1:0] vtx [3][3];
  logic signed [EDGE_W-1:0]  eab [3];
  logic signed [EDGE_W-1:0]  eac [3];
  logic signed [EDGE_W-1:0]  ebc [3];

  logic [4:0]                 op;
  logic                       ph;
  logic signed [OPND_W-1:0]   ma, mb;
  logic signed [PROD_W-1:0]   prod;
  logic signed [CROSS_W-1:0]  cr [3];
  logic [MAG_W-1:0]           crm [3];
  logic [SUM_W-1:0]           s_acc;
  logic [SUM_W-1:0]           p_ext;
  dot_t                       dot_a, dot_b, dot_c;

  logic [SUM_W-1:0]  rad;
  logic [ROOT_W:0]   rem;
  root_t             root;
  logic [5:0]        sq_cnt;
  logic [ROOT_W+2:0] rem_sh;
  logic [ROOT_W+2:0] trial;
  logic              sq_ge;

  logic [1:0] dk;
  dot_t       div_dot;
  logic       div_start;
  logic       div_done;
  cot_t       div_cot;
  cot_t       cot_a, cot_b, cot_c;

  logic take;
  assign req_stall = (state != S_IDLE);
  assign take      = req_valid && !req_stall;

  // Read address and range flag follow the corner being fetched.
  always_comb begin
    unique case (state)
      S_RB: begin
        rd_addr    = slot_addr(cb);
        rd_ok_next = slot_ok(cb);
      end
      S_RC: begin
        rd_addr    = slot_addr(cc);
        rd_ok_next = slot_ok(cc);
      end
      default: begin
        rd_addr    = slot_addr(ca);
        rd_ok_next = slot_ok(ca);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (take && !command && slot_ok(vertex_slot)) begin
      mem[slot_addr(vertex_slot)] <= {fit(coord_z), fit(coord_y), fit(coord_x)};
    end
    rd_data <= mem[rd_addr];
    rd_ok   <= rd_ok_next;
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      crm[k] = cr[k][CROSS_W-1] ? MAG_W'(-cr[k]) : MAG_W'(cr[k]);
    end
    ma = '0;
    mb = '0;
    unique case (op)
      5'd0: begin ma = sx(eab[1]); mb = sx(eac[2]); end
      5'd1: begin ma = sx(eab[2]); mb = sx(eac[1]); end
      5'd2: begin ma = sx(eab[2]); mb = sx(eac[0]); end
      5'd3: begin ma = sx(eab[0]); mb = sx(eac[2]); end
      5'd4: begin ma = sx(eab[0]); mb = sx(eac[1]); end
      5'd5: begin ma = sx(eab[1]); mb = sx(eac[0]); end
      OP_SQ + 5'd0: begin ma = {1'b0, crm[0][24:0]};  mb = {1'b0, crm[0][24:0]};  end
      OP_SQ + 5'd1: begin ma = {1'b0, crm[0][24:0]};  mb = {2'b0, crm[0][48:25]}; end
      OP_SQ + 5'd2: begin ma = {2'b0, crm[0][48:25]}; mb = {2'b0, crm[0][48:25]}; end
      OP_SQ + 5'd3: begin ma = {1'b0, crm[1][24:0]};  mb = {1'b0, crm[1][24:0]};  end
      OP_SQ + 5'd4: begin ma = {1'b0, crm[1][24:0]};  mb = {2'b0, crm[1][48:25]}; end
      OP_SQ + 5'd5: begin ma = {2'b0, crm[1][48:25]}; mb = {2'b0, crm[1][48:25]}; end
      OP_SQ + 5'd6: begin ma = {1'b0, crm[2][24:0]};  mb = {1'b0, crm[2][24:0]};  end
      OP_SQ + 5'd7: begin ma = {1'b0, crm[2][24:0]};  mb = {2'b0, crm[2][48:25]}; end
      OP_SQ + 5'd8: begin ma = {2'b0, crm[2][48:25]}; mb = {2'b0, crm[2][48:25]}; end
      OP_DA + 5'd0: begin ma = sx(eab[0]); mb = sx(eac[0]); end
      OP_DA + 5'd1: begin ma = sx(eab[1]); mb = sx(eac[1]); end
      OP_DA + 5'd2: begin ma = sx(eab[2]); mb = sx(eac[2]); end
      OP_DB + 5'd0: begin ma = sx(eab[0]); mb = sx(ebc[0]); end
      OP_DB + 5'd1: begin ma = sx(eab[1]); mb = sx(ebc[1]); end
      OP_DB + 5'd2: begin ma = sx(eab[2]); mb = sx(ebc[2]); end
      OP_DC + 5'd0: begin ma = sx(eac[0]); mb = sx(ebc[0]); end
      OP_DC + 5'd1: begin ma = sx(eac[1]); mb = sx(ebc[1]); end
      OP_DC + 5'd2: begin ma = sx(eac[2]); mb = sx(ebc[2]); end
      default: begin ma = '0; mb = '0; end
    endcase
    p_ext = SUM_W'($unsigned(prod));
  end

  // One step of the bit-serial square root: two radicand bits enter each cycle.
  always_comb begin
    rem_sh = {rem, rad[SUM_W-1 -: 2]};
    trial  = (ROOT_W+3)'({root, 2'b01});
    sq_ge  = rem_sh >= trial;
  end

  always_comb begin
    unique case (dk)
      2'd1:    div_dot = dot_b;
      2'd2:    div_dot = dot_c;
      default: div_dot = dot_a;
    endcase
  end

  assign div_start = (state == S_DGO);

  tcw_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .dot   (div_dot),
    .m     (root),
    .done  (div_done),
    .cot   (div_cot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
    end else begin
      // A result taken while the next one is ready is replaced below instead.
      if (res_valid && !res_stall && state != S_DONE) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (take && command) begin
            ca    <= corner_a;
            cb    <= corner_b;
            cc    <= corner_c;
            state <= S_RA;
          end
        end
        S_RA: state <= S_RB;
        S_RB: begin
          for (int k = 0; k < 3; k++) begin
            vtx[0][k] <= rd_ok ? rd_data[k*COORD_W +: COORD_W] : '0;
          end
          state <= S_RC;
        end
        S_RC: begin
          for (int k = 0; k < 3; k++) begin
            vtx[1][k] <= rd_ok ? rd_data[k*COORD_W +: COORD_W] : '0;
          end
          state <= S_CAP;
        end
        S_CAP: begin
          for (int k = 0; k < 3; k++) begin
            vtx[2][k] <= rd_ok ? rd_data[k*COORD_W +: COORD_W] : '0;
          end
          state <= S_EDGE;
        end
        S_EDGE: begin
          for (int k = 0; k < 3; k++) begin
            eab[k] <= EDGE_W'(vtx[1][k]) - EDGE_W'(vtx[0][k]);
            eac[k] <= EDGE_W'(vtx[2][k]) - EDGE_W'(vtx[0][k]);
            ebc[k] <= EDGE_W'(vtx[2][k]) - EDGE_W'(vtx[1][k]);
          end
          s_acc <= '0;
          dot_a <= '0;
          dot_b <= '0;
          dot_c <= '0;
          op    <= '0;
          ph    <= 1'b0;
          state <= S_MUL;
        end
        S_MUL: begin
          ph <= !ph;
          if (!ph) begin
            prod <= ma * mb;
          end else begin
            unique case (op)
              5'd0: cr[0] <= CROSS_W'(prod);
              5'd1: cr[0] <= cr[0] - CROSS_W'(prod);
              5'd2: cr[1] <= CROSS_W'(prod);
              5'd3: cr[1] <= cr[1] - CROSS_W'(prod);
              5'd4: cr[2] <= CROSS_W'(prod);
              5'd5: cr[2] <= cr[2] - CROSS_W'(prod);
              OP_SQ + 5'd0, OP_SQ + 5'd3, OP_SQ + 5'd6: s_acc <= s_acc + p_ext;
              OP_SQ + 5'd1, OP_SQ + 5'd4, OP_SQ + 5'd7: s_acc <= s_acc + (p_ext << 26);
              OP_SQ + 5'd2, OP_SQ + 5'd5, OP_SQ + 5'd8: s_acc <= s_acc + (p_ext << 50);
              OP_DA + 5'd0, OP_DA + 5'd1, OP_DA + 5'd2: dot_a <= dot_a + DOT_W'(prod);
              OP_DB + 5'd0, OP_DB + 5'd1, OP_DB + 5'd2: dot_b <= dot_b - DOT_W'(prod);
              OP_DC + 5'd0, OP_DC + 5'd1, OP_DC + 5'd2: dot_c <= dot_c + DOT_W'(prod);
              default: ;
            endcase
            op <= op + 5'd1;
            if (op == OP_LAST) begin
              state <= S_SQI;
            end
          end
        end
        S_SQI: begin
          rad    <= s_acc;
          rem    <= '0;
          root   <= '0;
          sq_cnt <= 6'(ROOT_W - 1);
          if (s_acc == '0) begin
            cot_a <= '0;
            cot_b <= '0;
            cot_c <= '0;
            state <= S_DONE;
          end else begin
            state <= S_SQRT;
          end
        end
        S_SQRT: begin
          rad    <= rad << 2;
          rem    <= sq_ge ? (ROOT_W+1)'(rem_sh - trial) : (ROOT_W+1)'(rem_sh);
          root   <= {root[ROOT_W-2:0], sq_ge};
          sq_cnt <= sq_cnt - 6'd1;
          if (sq_cnt == 6'd0) begin
            dk    <= 2'd0;
            state <= S_DGO;
          end
        end
        S_DGO: state <= S_DWT;
        S_DWT: begin
          if (div_done) begin
            unique case (dk)
              2'd1:    cot_b <= div_cot;
              2'd2:    cot_c <= div_cot;
              default: cot_a <= div_cot;
            endcase
            dk    <= dk + 2'd1;
            state <= (dk == 2'd2) ? S_DONE : S_DGO;
          end
        end
        S_DONE: begin
          if (!res_valid || !res_stall) begin
            cot_at_a   <= cot_a;
            cot_at_b   <= cot_b;
            cot_at_c   <= cot_c;
            degenerate <= (s_acc == '0);
            tri_area   <= (s_acc == '0) ? '0 : AREA_W'(root >> AREA_SH);
            res_valid  <= 1'b1;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== sim/tb.sv =====
// Self-checking testbench for triangle_cotangent_weights_core: vertex writes and triangle queries.
// Uses tcw_pkg and the core; a cotangent and area predictor or typed values check each result.
module tb;
  import tcw_pkg::*;

  localparam int CYCLE_LIMIT = 2000000;
  localparam int RANDOM_ITEMS = 1730;
  localparam int QUIET_FROM = 1500;
  localparam int SLOTS = 1 << SLOT_W;

  // Request commands as carried on the command port.
  typedef enum bit {CMD_WRITE = 1'b0, CMD_QUERY = 1'b1} command_e;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [AREA_W-1:0] area_t;

  typedef struct {
    command_e cmd;
    logic [SLOT_W-1:0] slot;
    coord_t x, y, z;
    logic [SLOT_W-1:0] a, b, c;
    bit known;          // expected result typed into the table
    cot_t ca, cb, cc;
    area_t area;
    bit degen;
  } request_t;

  typedef struct {
    cot_t ca, cb, cc;
    area_t area;
    bit degen;
  } weights_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  logic command = 1'b0;
  logic [SLOT_W-1:0] vertex_slot = '0;
  coord_t coord_x = '0, coord_y = '0, coord_z = '0;
  logic [SLOT_W-1:0] corner_a = '0, corner_b = '0, corner_c = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  cot_t cot_at_a, cot_at_b, cot_at_c;
  area_t tri_area;
  logic degenerate;

  // The predictor's own copy of the vertex store, plus which slots hold a vertex.
  coord_t store_x [SLOTS];
  coord_t store_y [SLOTS];
  coord_t store_z [SLOTS];
  bit filled [SLOTS];
  int filled_slots[$];

  weights_t pending_weights[$];
  request_t directed[$];
  int mismatches = 0;
  int cycles = 0;
  bit quiet = 1'b0;
  int stall_left = 0;

  triangle_cotangent_weights_core DUT (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall),
    .command(command), .vertex_slot(vertex_slot),
    .coord_x(coord_x), .coord_y(coord_y), .coord_z(coord_z),
    .corner_a(corner_a), .corner_b(corner_b), .corner_c(corner_c),
    .res_valid(res_valid), .res_stall(res_stall),
    .cot_at_a(cot_at_a), .cot_at_b(cot_at_b), .cot_at_c(cot_at_c),
    .tri_area(tri_area), .degenerate(degenerate)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Cotangent from the exact dot product and the floored cross magnitude, rounded towards
  // zero and saturated once the Q16.16 quotient reaches 2^31.
  function automatic cot_t corner_cot(longint dot, logic [127:0] root);
    logic [127:0] mag;
    logic [127:0] quo;
    mag = (dot < 0) ? 128'(-dot) : 128'(dot);
    quo = (mag << FRAC_W) / root;
    if (quo >= 128'h8000_0000) return (dot < 0) ? COT_MIN : COT_MAX;
    return (dot < 0) ? -cot_t'(quo[31:0]) : cot_t'(quo[31:0]);
  endfunction

  function automatic weights_t triangle_weights(int ia, int ib, int ic);
    longint p[3][3];
    longint u[3], v[3], cr[3];
    logic [127:0] sum, root, trial, mag;
    weights_t w;
    p[0] = '{longint'(store_x[ia]), longint'(store_y[ia]), longint'(store_z[ia])};
    p[1] = '{longint'(store_x[ib]), longint'(store_y[ib]), longint'(store_z[ib])};
    p[2] = '{longint'(store_x[ic]), longint'(store_y[ic]), longint'(store_z[ic])};
    for (int k = 0; k < 3; k++) begin
      u[k] = p[1][k] - p[0][k];
      v[k] = p[2][k] - p[0][k];
    end
    cr[0] = u[1] * v[2] - u[2] * v[1];
    cr[1] = u[2] * v[0] - u[0] * v[2];
    cr[2] = u[0] * v[1] - u[1] * v[0];
    sum = '0;
    for (int k = 0; k < 3; k++) begin
      mag = (cr[k] < 0) ? 128'(-cr[k]) : 128'(cr[k]);
      sum += mag * mag;
    end
    w = '{ca: '0, cb: '0, cc: '0, area: '0, degen: 1'b1};
    if (sum == 0) return w;
    root = '0;
    for (int i = 52; i >= 0; i--) begin
      trial = root | (128'd1 << i);
      if (trial * trial <= sum) root = trial;
    end
    w.degen = 1'b0;
    w.ca = corner_cot((p[1][0]-p[0][0])*(p[2][0]-p[0][0]) + (p[1][1]-p[0][1])*(p[2][1]-p[0][1])
                      + (p[1][2]-p[0][2])*(p[2][2]-p[0][2]), root);
    w.cb = corner_cot((p[0][0]-p[1][0])*(p[2][0]-p[1][0]) + (p[0][1]-p[1][1])*(p[2][1]-p[1][1])
                      + (p[0][2]-p[1][2])*(p[2][2]-p[1][2]), root);
    w.cc = corner_cot((p[0][0]-p[2][0])*(p[1][0]-p[2][0]) + (p[0][1]-p[2][1])*(p[1][1]-p[2][1])
                      + (p[0][2]-p[2][2])*(p[1][2]-p[2][2]), root);
    root = root >> AREA_SH;
    w.area = (root > 128'hFFFF_FFFF_FFFF) ? '1 : root[AREA_W-1:0];
    return w;
  endfunction

  function automatic request_t vertex_write(int slot, coord_t x, coord_t y, coord_t z);
    request_t r;
    r = '{cmd: CMD_WRITE, slot: SLOT_W'(slot), x: x, y: y, z: z, a: SLOT_W'($urandom),
          b: SLOT_W'($urandom), c: SLOT_W'($urandom), known: 1'b0, ca: '0, cb: '0, cc: '0,
          area: '0, degen: 1'b0};
    return r;
  endfunction

  function automatic request_t triangle_query(int a, int b, int c);
    request_t r;
    r = '{cmd: CMD_QUERY, slot: SLOT_W'($urandom), x: coord_t'($urandom),
          y: coord_t'($urandom), z: coord_t'($urandom), a: SLOT_W'(a), b: SLOT_W'(b),
          c: SLOT_W'(c), known: 1'b0, ca: '0, cb: '0, cc: '0, area: '0, degen: 1'b0};
    return r;
  endfunction

  function automatic request_t known_query(int a, int b, int c, cot_t ca, cot_t cb, cot_t cc,
                                           area_t area, bit degen);
    request_t r;
    r = triangle_query(a, b, c);
    r.known = 1'b1;
    r.ca = ca; r.cb = cb; r.cc = cc; r.area = area; r.degen = degen;
    return r;
  endfunction

  function automatic coord_t random_coord();
    unique case ($urandom_range(0, 5))
      0: return $urandom_range(0, 1) ? 24'sh7F_FFFF : 24'sh80_0000;
      1, 2: return coord_t'($signed($urandom_range(0, 32768)) - 16384);
      default: return coord_t'($urandom);
    endcase
  endfunction

  // Offers one request, with an optional idle burst in front, and records its effect on
  // the store or the expected weights once the core has taken it.
  task automatic offer_request(request_t r);
    weights_t w;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    req_valid <= 1'b1;
    command <= r.cmd;
    vertex_slot <= r.slot;
    coord_x <= r.x; coord_y <= r.y; coord_z <= r.z;
    corner_a <= r.a; corner_b <= r.b; corner_c <= r.c;
    do @(posedge clk); while (req_stall);
    if (r.cmd == CMD_WRITE) begin
      store_x[r.slot] = r.x; store_y[r.slot] = r.y; store_z[r.slot] = r.z;
      if (!filled[r.slot]) filled_slots.push_back(r.slot);
      filled[r.slot] = 1'b1;
    end else if (r.known) begin
      pending_weights.push_back('{ca: r.ca, cb: r.cb, cc: r.cc, area: r.area, degen: r.degen});
    end else begin
      w = triangle_weights(r.a, r.b, r.c);
      pending_weights.push_back(w);
    end
  endtask

  // Result side: compare each taken result with the oldest expectation, and hold off the
  // core in random bursts except during the quiet tail of the run.
  always @(posedge clk) begin
    weights_t w;
    if (rst) begin
      res_stall <= 1'b0;
    end else begin
      if (res_valid && !res_stall) begin
        if (pending_weights.size() == 0) begin
          $error("result arrived with no query outstanding");
          mismatches++;
        end else begin
          w = pending_weights.pop_front();
          if (cot_at_a !== w.ca) begin
            $error("cot_at_a: expected %0d, got %0d", w.ca, cot_at_a);
            mismatches++;
          end
          if (cot_at_b !== w.cb) begin
            $error("cot_at_b: expected %0d, got %0d", w.cb, cot_at_b);
            mismatches++;
          end
          if (cot_at_c !== w.cc) begin
            $error("cot_at_c: expected %0d, got %0d", w.cc, cot_at_c);
            mismatches++;
          end
          if (tri_area !== w.area) begin
            $error("tri_area: expected %0d, got %0d", w.area, tri_area);
            mismatches++;
          end
          if (degenerate !== w.degen) begin
            $error("degenerate: expected %0d, got %0d", w.degen, degenerate);
            mismatches++;
          end
        end
      end
      if (!quiet && stall_left != 0) begin
        res_stall <= 1'b1;
        stall_left <= stall_left - 1;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        res_stall <= 1'b1;
        stall_left <= $urandom_range(0, 14);
      end else begin
        res_stall <= 1'b0;
      end
    end
  end

  // A stuck handshake ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    request_t r;
    int a, b, c;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed part: a unit right triangle, degenerate cases, full-scale coordinates and
    // slivers thin enough to saturate the cotangent both ways.
    directed.push_back(vertex_write(0, 24'sd0, 24'sd0, 24'sd0));
    directed.push_back(vertex_write(1, 24'sd4096, 24'sd0, 24'sd0));
    directed.push_back(vertex_write(2, 24'sd0, 24'sd4096, 24'sd0));
    directed.push_back(vertex_write(4095, 24'sh7F_FFFF, 24'sh7F_FFFF, 24'sh7F_FFFF));
    directed.push_back(vertex_write(3, 24'sh80_0000, 24'sh80_0000, 24'sh80_0000));
    directed.push_back(vertex_write(4, 24'sh7F_FFFF, 24'sd0, 24'sd0));
    directed.push_back(vertex_write(5, 24'sh7F_FFFF, 24'sd1, 24'sd0));
    directed.push_back(vertex_write(6, 24'sh80_0000, 24'sd1, 24'sd0));
    directed.push_back(vertex_write(2730, 24'sh55_5555, -24'sh2A_AAAA, 24'sh12_3456));
    directed.push_back(vertex_write(1365, -24'sh55_5555, 24'sh2A_AAAA, 24'sh7F_0001));
    directed.push_back(known_query(0, 1, 2, 32'sd0, 32'sd65536, 32'sd65536, 48'd2048, 1'b0));
    directed.push_back(known_query(0, 0, 0, 32'sd0, 32'sd0, 32'sd0, 48'd0, 1'b1));
    directed.push_back(known_query(1, 1, 2, 32'sd0, 32'sd0, 32'sd0, 48'd0, 1'b1));
    directed.push_back(known_query(4095, 3, 0, 32'sd0, 32'sd0, 32'sd0, 48'd0, 1'b1));
    directed.push_back(triangle_query(0, 4, 5));
    directed.push_back(triangle_query(0, 4, 6));
    directed.push_back(triangle_query(3, 4095, 4));
    directed.push_back(triangle_query(2730, 1365, 4095));
    directed.push_back(triangle_query(6, 2730, 3));
    foreach (directed[i]) offer_request(directed[i]);

    // Random part: writes scattered over the store and queries over filled slots only.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n >= QUIET_FROM) quiet = 1'b1;
      if (n == RANDOM_ITEMS / 2) begin
        // Let the core drain completely before carrying on.
        req_valid <= 1'b0;
        while (pending_weights.size() != 0) @(posedge clk);
      end
      if ($urandom_range(0, 9) < 4) begin
        r = vertex_write($urandom_range(0, SLOTS - 1), random_coord(), random_coord(),
                         random_coord());
      end else begin
        a = filled_slots[$urandom_range(0, filled_slots.size() - 1)];
        b = filled_slots[$urandom_range(0, filled_slots.size() - 1)];
        c = filled_slots[$urandom_range(0, filled_slots.size() - 1)];
        if ($urandom_range(0, 9) == 0) b = a;
        r = triangle_query(a, b, c);
      end
      offer_request(r);
    end
    req_valid <= 1'b0;

    while (pending_weights.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/tcw_pkg.sv
hw/rtl/tcw_div.sv
hw/rtl/triangle_cotangent_weights_core.sv
sim/tb.sv
